// ===== hdl/gln_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gln_pkg
// Types, character constants and helpers shared by the G-code line
// normalizer modules.
// ----------------------------------------------------------------------------
package gln_pkg;

    localparam logic [7:0] C_NUL    = 8'h00;
    localparam logic [7:0] C_SLASH  = 8'h2F;
    localparam logic [7:0] C_QUERY  = 8'h3F;
    localparam logic [7:0] C_LPAREN = 8'h28;
    localparam logic [7:0] C_RPAREN = 8'h29;
    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_DEL    = 8'h7F;
    localparam logic [7:0] C_UP_M   = 8'h4D;
    localparam logic [7:0] C_UP_S   = 8'h53;
    localparam logic [7:0] C_UP_G   = 8'h47;

    typedef enum logic [6:0] {
        MODE_START   = 7'b0000001,
        MODE_COMMAND = 7'b0000010,
        MODE_DELETED = 7'b0000100,
        MODE_QUERY   = 7'b0001000,
        MODE_PREFIX  = 7'b0010000,
        MODE_MESSAGE = 7'b0100000,
        MODE_SKIP    = 7'b1000000
    } t_mode;

    typedef enum logic [1:0] {
        KIND_COMMAND = 2'd0,
        KIND_DELETED = 2'd1,
        KIND_EMPTY   = 2'd2,
        KIND_QUERY   = 2'd3
    } t_kind;

    typedef struct packed {
        t_mode      mode;
        logic [1:0] match_cnt;
        logic       nonempty;
        logic       msg_found;
    } t_state;

    typedef struct packed {
        logic [7:0] out_char;
        logic       is_message;
        logic       block_end;
        t_kind      block_kind;
        logic       had_message;
    } t_result;

    localparam t_state STATE_RESET = '{
        mode:      MODE_START,
        match_cnt: 2'd0,
        nonempty:  1'b0,
        msg_found: 1'b0
    };

    function automatic logic [7:0] upper_of(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7A) begin
            return c - 8'd32;
        end
        return c;
    endfunction

    function automatic logic is_invalid_punct(input logic [7:0] c);
        logic r;
        unique case (c)
            8'h21, 8'h24, 8'h25, 8'h2C, 8'h3B, 8'h3A, 8'h3F,
            8'h40, 8'h5E, 8'h5F, 8'h7E, 8'h60, 8'h27, 8'h22: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/gln_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gln_step
// Classifies one byte against the current block state, gives the next
// state and at most one result item.
// ----------------------------------------------------------------------------
module gln_step (
    input  wire logic [7:0]       i_char,
    input  wire gln_pkg::t_state  i_state,
    output gln_pkg::t_state       o_state,
    output gln_pkg::t_result      o_res,
    output logic                  o_emit
);
    import gln_pkg::*;

    logic [7:0] up;
    logic [7:0] want;
    logic       is_alnum;
    logic       is_drop;

    always_comb begin
        up       = upper_of(i_char);
        is_alnum = (up >= 8'h41 && up <= 8'h5A) || (up >= 8'h30 && up <= 8'h39);
        is_drop  = (up <= C_SPACE) || (up >= C_DEL) || is_invalid_punct(up);
        unique case (i_state.match_cnt)
            2'd0:    want = C_UP_M;
            2'd1:    want = C_UP_S;
            default: want = C_UP_G;
        endcase
    end

    always_comb begin
        o_state = i_state;
        o_emit  = 1'b0;
        o_res   = '{
            out_char:    i_char,
            is_message:  1'b0,
            block_end:   1'b0,
            block_kind:  KIND_COMMAND,
            had_message: 1'b0
        };

        if (i_char == C_NUL) begin
            o_emit           = 1'b1;
            o_res.out_char   = C_NUL;
            o_res.block_end  = 1'b1;
            o_res.had_message = i_state.msg_found;
            if (i_state.mode == MODE_DELETED) begin
                o_res.block_kind = KIND_DELETED;
            end else if (i_state.mode == MODE_QUERY) begin
                o_res.block_kind = KIND_QUERY;
            end else begin
                o_res.block_kind = i_state.nonempty ? KIND_COMMAND : KIND_EMPTY;
            end
            o_state = STATE_RESET;
        end else begin
            unique case (i_state.mode)
                MODE_START, MODE_COMMAND: begin
                    if (i_state.mode == MODE_START && i_char == C_SLASH) begin
                        o_state.mode = MODE_DELETED;
                    end else if (i_state.mode == MODE_START && i_char == C_QUERY) begin
                        o_state.mode = MODE_QUERY;
                        o_emit       = 1'b1;
                    end else begin
                        o_state.mode = MODE_COMMAND;
                        if (is_alnum) begin
                            o_state.nonempty = 1'b1;
                            o_emit           = 1'b1;
                            o_res.out_char   = up;
                        end else if (up == C_LPAREN) begin
                            o_state.mode      = MODE_PREFIX;
                            o_state.match_cnt = 2'd0;
                        end else if (!is_drop) begin
                            o_state.nonempty = 1'b1;
                            o_emit           = 1'b1;
                            o_res.out_char   = up;
                        end
                    end
                end
                MODE_DELETED: begin
                end
                MODE_QUERY: begin
                    o_emit = 1'b1;
                end
                MODE_PREFIX: begin
                    if (up != want) begin
                        o_state.mode      = MODE_SKIP;
                        o_state.match_cnt = 2'd0;
                    end else if (i_state.match_cnt >= 2'd2) begin
                        o_state.mode      = MODE_MESSAGE;
                        o_state.msg_found = 1'b1;
                        o_state.match_cnt = 2'd0;
                    end else begin
                        o_state.match_cnt = i_state.match_cnt + 2'd1;
                    end
                end
                MODE_MESSAGE: begin
                    if (i_char == C_RPAREN) begin
                        o_state.mode = MODE_SKIP;
                    end else begin
                        o_emit           = 1'b1;
                        o_res.is_message = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/gcode_line_normalizer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gcode_line_normalizer
// Normalizes a G-code block byte by byte: upper-cased command text, raw
// query text, MSG comment text and one status item at the end of each block.
// ----------------------------------------------------------------------------
//  channel | valid       | ready       | payload
//  in      | i_in_valid  | o_in_ready  | i_in_char
//  out     | o_out_valid | i_out_ready | o_out_char, o_is_message, o_block_end,
//          |             |             | o_block_kind, o_had_message
//
//  One item per cycle while the output is not stalled; a taken item passes
//  the input register, then classify and block-state update into the result
//  register. Items that give no result still pass through the same stage.
//  Reset returns the block state to start of block and empties both stages.
//  A stalled output holds the pipeline; input stays open while the result
//  register is empty or being taken.
// ----------------------------------------------------------------------------
module gcode_line_normalizer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_in_char,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_out_char,
    output logic             o_is_message,
    output logic             o_block_end,
    output logic [1:0]       o_block_kind,
    output logic             o_had_message
);
    import gln_pkg::*;

    logic       r_in_valid;
    logic       n_in_valid;
    logic [7:0] r_in_char;
    t_state     r_state;
    t_state     n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    t_result    r_out;
    t_result    step_res;
    logic       step_emit;
    logic       advance;

    gln_step u_step (
        .i_char  (r_in_char),
        .i_state (r_state),
        .o_state (n_state),
        .o_res   (step_res),
        .o_emit  (step_emit)
    );

    always_comb begin
        advance     = r_in_valid && (!r_out_valid || i_out_ready);
        o_in_ready  = !r_in_valid || advance;
        n_in_valid  = (i_in_valid && o_in_ready) || (r_in_valid && !advance);
        n_out_valid = advance ? step_emit : (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_char <= i_in_char;
        end
        if (advance && step_emit) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_char    = r_out.out_char;
    assign o_is_message  = r_out.is_message;
    assign o_block_end   = r_out.block_end;
    assign o_block_kind  = r_out.block_kind;
    assign o_had_message = r_out.had_message;

`ifndef SYNTHESIS
    a_end_item_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_block_end |-> o_out_char == C_NUL && !o_is_message)
        else $error("end item carries a character");

    a_char_item_no_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_block_end |-> o_block_kind == KIND_COMMAND && !o_had_message)
        else $error("character item carries status");

    a_end_resets_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_char == C_NUL |=> r_state == STATE_RESET)
        else $error("block state not cleared at block end");

    a_count_only_in_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.match_cnt != 2'd0 |-> r_state.mode == MODE_PREFIX)
        else $error("prefix count outside comment prefix");

    a_reset_to_start: assert property (@(posedge i_clk)
        !i_rst_n |=> r_state.mode == MODE_START && !r_in_valid && !r_out_valid)
        else $error("reset did not return to start of block");
`endif

endmodule

`default_nettype wire

// ===== tb/gcode_line_normalizer_test.sv =====
// ----------------------------------------------------------------------------
// gcode_line_normalizer_test
// Self-checking bench for the G-code line normalizer. A directed table covers
// empty, deleted and query blocks, case folding, dropped bytes and MSG
// comments, then random well-formed blocks mixed with noise. A behavioral
// model of the block state predicts results the table leaves open. Both
// handshakes idle at random; results are checked in order, field by field.
// ----------------------------------------------------------------------------
module gcode_line_normalizer_test;
    import gln_pkg::*;

    typedef struct {
        logic [7:0] ch;
        bit         typed;
        bit         has;
        t_result    res;
    } t_dir_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic [7:0] i_in_char = 8'h00;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_char;
    logic       o_is_message;
    logic       o_block_end;
    logic [1:0] o_block_kind;
    logic       o_had_message;

    // invalid punctuation: ! $ % , ; : ? @ ^ _ ~ ` ' "
    logic [7:0] bad_punct [0:13] = '{8'h21, 8'h24, 8'h25, 8'h2C, 8'h3B, 8'h3A, 8'h3F,
                                     8'h40, 8'h5E, 8'h5F, 8'h7E, 8'h60, 8'h27, 8'h22};

    t_mode      blk_mode = MODE_START;
    logic [1:0] prefix_hits = 2'd0;
    bit         cmd_seen = 1'b0;
    bit         msg_seen = 1'b0;

    t_result    pending_out[$];
    t_dir_row   dir_rows[$];
    int         mismatches = 0;
    int         items_sent = 0;
    int         results_seen = 0;
    int         msg_chars = 0;
    int         msg_blocks = 0;
    int         kind_tally [0:3] = '{0, 0, 0, 0};
    bit         sender_calm = 1'b0;
    bit         sink_calm = 1'b0;
    int         sink_hold = 0;

    gcode_line_normalizer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_char     (i_in_char),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_char    (o_out_char),
        .o_is_message  (o_is_message),
        .o_block_end   (o_block_end),
        .o_block_kind  (o_block_kind),
        .o_had_message (o_had_message)
    );

    always #10 i_clk = ~i_clk;

    function automatic int pick_gap(input bit calm);
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 96) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    function automatic bit punct_rejected(input logic [7:0] c);
        foreach (bad_punct[i]) begin
            if (c == bad_punct[i]) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_result char_res(input logic [7:0] c);
        t_result r;
        r = '0;
        r.out_char = c;
        return r;
    endfunction

    function automatic t_result end_res(input t_kind kind, input bit had);
        t_result r;
        r = '0;
        r.block_end = 1'b1;
        r.block_kind = kind;
        r.had_message = had;
        return r;
    endfunction

    // command byte: fold case, drop blanks and invalid marks, ( opens comment
    function automatic bit command_char(input logic [7:0] ch, inout t_result r);
        logic [7:0] u;
        u = fold_case(ch);
        r.out_char = u;
        if ((u >= "A" && u <= "Z") || (u >= "0" && u <= "9")) begin
            cmd_seen = 1'b1;
            return 1'b1;
        end
        if (u == C_LPAREN) begin
            blk_mode = MODE_PREFIX;
            prefix_hits = 2'd0;
            return 1'b0;
        end
        if (u <= C_SPACE || u >= C_DEL || punct_rejected(u)) begin
            return 1'b0;
        end
        cmd_seen = 1'b1;
        return 1'b1;
    endfunction

    function automatic bit normalize_byte(input logic [7:0] ch, output t_result r);
        logic [7:0] want;
        t_kind      kind;
        bit         emit;
        r = '0;
        emit = 1'b0;
        if (ch == C_NUL) begin
            if (blk_mode == MODE_DELETED) begin
                kind = KIND_DELETED;
            end else if (blk_mode == MODE_QUERY) begin
                kind = KIND_QUERY;
            end else begin
                kind = cmd_seen ? KIND_COMMAND : KIND_EMPTY;
            end
            r = end_res(kind, msg_seen);
            blk_mode = MODE_START;
            prefix_hits = 2'd0;
            cmd_seen = 1'b0;
            msg_seen = 1'b0;
            return 1'b1;
        end
        r.out_char = ch;
        case (blk_mode)
            MODE_START: begin
                if (ch == C_SLASH) begin
                    blk_mode = MODE_DELETED;
                end else if (ch == C_QUERY) begin
                    blk_mode = MODE_QUERY;
                    emit = 1'b1;
                end else begin
                    blk_mode = MODE_COMMAND;
                    emit = command_char(ch, r);
                end
            end
            MODE_COMMAND: begin
                emit = command_char(ch, r);
            end
            MODE_QUERY: begin
                emit = 1'b1;
            end
            MODE_PREFIX: begin
                want = (prefix_hits == 2'd0) ? C_UP_M : (prefix_hits == 2'd1) ? C_UP_S : C_UP_G;
                if (fold_case(ch) != want) begin
                    blk_mode = MODE_SKIP;
                    prefix_hits = 2'd0;
                end else if (prefix_hits >= 2'd2) begin
                    blk_mode = MODE_MESSAGE;
                    msg_seen = 1'b1;
                    prefix_hits = 2'd0;
                end else begin
                    prefix_hits = prefix_hits + 2'd1;
                end
            end
            MODE_MESSAGE: begin
                if (ch == C_RPAREN) begin
                    blk_mode = MODE_SKIP;
                end else begin
                    r.is_message = 1'b1;
                    emit = 1'b1;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
        return emit;
    endfunction

    function automatic logic [7:0] mix_byte();
        logic [7:0] v;
        case ($urandom_range(0, 9))
            0, 1: v = "a" + 8'($urandom_range(0, 25));
            2: v = "A" + 8'($urandom_range(0, 25));
            3: v = "0" + 8'($urandom_range(0, 9));
            4: v = 8'($urandom_range(1, 255));
            5: v = 8'($urandom_range(8'h21, 8'h7E));
            6: v = $urandom_range(0, 4) == 0 ? C_DEL : 8'($urandom_range(1, 8'h20));
            7: v = 8'($urandom_range(8'h80, 8'hFF));
            8: v = $urandom_range(0, 1) ? C_LPAREN : C_RPAREN;
            default: v = bad_punct[$urandom_range(0, 13)];
        endcase
        return v;
    endfunction

    task automatic add_row(input logic [7:0] ch, input bit typed, input bit has,
                           input t_result res);
        t_dir_row row;
        row.ch = ch;
        row.typed = typed;
        row.has = has;
        row.res = res;
        dir_rows.push_back(row);
    endtask

    task automatic feed_item(input logic [7:0] ch, input bit typed, input bit has,
                             input t_result res);
        int      gap;
        bit      will_emit;
        t_result got;
        gap = pick_gap(sender_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_char <= ch;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        will_emit = normalize_byte(ch, got);
        if (typed) begin
            will_emit = has;
            got = res;
        end
        if (will_emit) begin
            pending_out.push_back(got);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_out.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (pending_out.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result: char %02h msg %0d end %0d kind %0d had %0d",
                                 o_out_char, o_is_message, o_block_end, o_block_kind,
                                 o_had_message);
                    end
                end else begin
                    want = pending_out.pop_front();
                    if (o_out_char !== want.out_char || o_is_message !== want.is_message ||
                        o_block_end !== want.block_end || o_block_kind !== want.block_kind ||
                        o_had_message !== want.had_message) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: exp char %02h msg %0d end %0d kind %0d had %0d",
                                     want.out_char, want.is_message, want.block_end,
                                     want.block_kind, want.had_message);
                            $display("          got char %02h msg %0d end %0d kind %0d had %0d",
                                     o_out_char, o_is_message, o_block_end, o_block_kind,
                                     o_had_message);
                        end
                    end
                end
                if (o_block_end === 1'b1) begin
                    kind_tally[o_block_kind]++;
                    if (o_had_message === 1'b1) begin
                        msg_blocks++;
                    end
                end else if (o_is_message === 1'b1) begin
                    msg_chars++;
                end
            end
            if ($urandom_range(0, 199) == 0) begin
                sink_calm = !sink_calm;
            end
            if (sink_hold > 0) begin
                sink_hold--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                sink_hold = pick_gap(sink_calm);
            end
        end
    end

    initial begin
        logic [7:0] blk[$];
        int         r;
        int         len;
        int         cut;
        bit         mid_drained;
        logic [7:0] letter;
        mid_drained = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty block
        add_row(C_NUL, 1, 1, end_res(KIND_EMPTY, 1'b0));
        // deleted block
        add_row(C_SLASH, 1, 0, '0);
        add_row("x", 1, 0, '0);
        add_row(C_NUL, 1, 1, end_res(KIND_DELETED, 1'b0));
        // query passes raw bytes
        add_row(C_QUERY, 1, 1, char_res(C_QUERY));
        add_row(8'hFF, 1, 1, char_res(8'hFF));
        add_row(C_NUL, 1, 1, end_res(KIND_QUERY, 1'b0));
        // command with drops and a non-MSG comment
        add_row("g", 1, 1, char_res("G"));
        add_row("1", 0, 0, '0);
        add_row(C_SPACE, 1, 0, '0);
        add_row("!", 1, 0, '0);
        add_row(8'h80, 1, 0, '0);
        add_row(".", 0, 0, '0);
        add_row(C_LPAREN, 0, 0, '0);
        add_row("x", 0, 0, '0);
        add_row(C_NUL, 0, 0, '0);
        // message only, bytes after ')' dropped
        add_row(C_LPAREN, 0, 0, '0);
        add_row("m", 0, 0, '0);
        add_row("s", 0, 0, '0);
        add_row("g", 0, 0, '0);
        add_row(8'h01, 0, 0, '0);
        add_row(C_RPAREN, 0, 0, '0);
        add_row("A", 0, 0, '0);
        add_row(C_NUL, 1, 1, end_res(KIND_EMPTY, 1'b1));
        // comment shorter than the prefix
        add_row(C_LPAREN, 0, 0, '0);
        add_row(C_UP_M, 0, 0, '0);
        add_row(C_NUL, 1, 1, end_res(KIND_EMPTY, 1'b0));

        foreach (dir_rows[i]) begin
            feed_item(dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].has, dir_rows[i].res);
        end
        wait_drained();

        while (items_sent < 1150) begin
            blk.delete();
            r = $urandom_range(0, 99);
            len = $urandom_range(0, 10);
            if ($urandom_range(0, 9) == 0) begin
                sender_calm = !sender_calm;
            end
            if (r < 8) begin
                blk.push_back(C_SLASH);
                repeat (len) blk.push_back(mix_byte());
            end else if (r < 16) begin
                blk.push_back(C_QUERY);
                repeat (len) blk.push_back(8'($urandom_range(1, 255)));
            end else if (r < 42) begin
                repeat ($urandom_range(0, 4)) blk.push_back(mix_byte());
                blk.push_back(C_LPAREN);
                cut = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : 3;
                for (int i = 0; i < 3; i++) begin
                    if (i == cut) begin
                        blk.push_back(mix_byte());
                        break;
                    end
                    letter = (i == 0) ? C_UP_M : (i == 1) ? C_UP_S : C_UP_G;
                    blk.push_back($urandom_range(0, 1) ? (letter | 8'h20) : letter);
                end
                repeat (len) blk.push_back(mix_byte());
                if ($urandom_range(0, 1)) begin
                    blk.push_back(C_RPAREN);
                    repeat ($urandom_range(0, 4)) blk.push_back(mix_byte());
                end
            end else if (r >= 47) begin
                repeat (len + 1) blk.push_back(mix_byte());
            end
            blk.push_back(C_NUL);
            foreach (blk[i]) begin
                feed_item(blk[i], 0, 0, '0);
            end
            if (!mid_drained && items_sent >= 575) begin
                wait_drained();
                mid_drained = 1'b1;
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("%0d items in, %0d results checked; blocks: %0d command, %0d deleted,",
                 items_sent, results_seen, kind_tally[0], kind_tally[1]);
        $display("%0d empty, %0d query; %0d with a MSG comment, %0d message chars",
                 kind_tally[2], kind_tally[3], msg_blocks, msg_chars);
        if (mismatches == 0 && pending_out.size() == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, pending_out.size());
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #(20 * 1000000);
        $display("timeout with %0d results outstanding", pending_out.size());
        $display("FAIL");
        $finish;
    end

endmodule
